FILE: rtl/gclp_pkg.sv
// gclp_pkg: constants, state encoding and helper functions for the g-code line parser
// used by gclp_out_buf and gcode_line_parser_unit; no dependencies
`timescale 1ns / 1ps

package gclp_pkg;

    localparam int FRAC_DIGITS = 3;
    localparam int VALUE_BITS  = 32;
    localparam int CODE_W      = 5;
    localparam int FIELD_W     = 4;
    localparam int FRAC_W      = (FRAC_DIGITS < 2) ? 1 : $clog2(FRAC_DIGITS + 1);
    localparam int WIDE_W      = VALUE_BITS + 4;

    // magnitude limit 2^(VALUE_BITS-1), also the accumulator ceiling
    localparam logic [VALUE_BITS-1:0] VAL_LIMIT = {1'b1, {(VALUE_BITS - 1){1'b0}}};

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // word letters, indexed by field
    localparam logic [FIELD_W-1:0] F_N = 4'd0;
    localparam logic [FIELD_W-1:0] F_G = 4'd1;
    localparam logic [FIELD_W-1:0] F_M = 4'd2;
    localparam logic [FIELD_W-1:0] F_X = 4'd3;
    localparam logic [FIELD_W-1:0] F_F = 4'd7;
    localparam int NUM_FIELDS = 10;
    localparam logic [7:0] WORD_LETTERS [NUM_FIELDS] = '{
        8'h4E, 8'h47, 8'h4D, 8'h58, 8'h59, 8'h5A, 8'h45, 8'h46, 8'h50, 8'h53
    };

    // command codes
    localparam logic [CODE_W-1:0] CK_UNKNOWN = 5'd0;
    localparam logic [CODE_W-1:0] CK_G_BASE  = 5'd1;
    localparam logic [CODE_W-1:0] CK_M_BASE  = 5'd7;
    localparam int G_COUNT = 6;
    localparam int M_COUNT = 15;
    localparam logic [15:0] G_TAB [G_COUNT] = '{16'd0, 16'd1, 16'd28, 16'd92, 16'd161, 16'd162};
    localparam logic [15:0] M_TAB [M_COUNT] = '{
        16'd0, 16'd12, 16'd13, 16'd14, 16'd15, 16'd16, 16'd105, 16'd110, 16'd208,
        16'd500, 16'd501, 16'd502, 16'd503, 16'd556, 16'd710
    };

    typedef enum logic [2:0] {
        ST_TOKEN   = 3'b001,
        ST_COMMENT = 3'b010,
        ST_NUM     = 3'b100
    } t_mode;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_FF);
    endfunction

    // m*10 + d, clipped at the magnitude limit
    function automatic logic [VALUE_BITS-1:0] sat_mul10_add(input logic [VALUE_BITS-1:0] m,
                                                          input logic [3:0] d);
        logic [WIDE_W-1:0] w;
        w = ({4'b0, m} << 3) + ({4'b0, m} << 1) + WIDE_W'(d);
        if (w > WIDE_W'(VAL_LIMIT)) begin
            return VAL_LIMIT;
        end
        return w[VALUE_BITS-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] map_code(input logic is_g, input logic neg,
                                                   input logic [VALUE_BITS-1:0] mag);
        logic [CODE_W-1:0] code;
        code = CK_UNKNOWN;
        if (!(neg && (mag != '0))) begin
            if (is_g) begin
                for (int i = 0; i < G_COUNT; i++) begin
                    if (mag == VALUE_BITS'(G_TAB[i])) begin
                        code = CK_G_BASE + CODE_W'(i);
                    end
                end
            end else begin
                for (int i = 0; i < M_COUNT; i++) begin
                    if (mag == VALUE_BITS'(M_TAB[i])) begin
                        code = CK_M_BASE + CODE_W'(i);
                    end
                end
            end
        end
        return code;
    endfunction

endpackage

FILE: rtl/gcode_line_parser_unit.sv
// gcode_line_parser_unit: top level of the character-serial g-code line parser
// depends on gclp_pkg and gclp_out_buf
`timescale 1ns / 1ps

// Takes one ASCII character per item and returns one code_kind item at every
// carriage return or NUL, naming the G or M command of the line just ended
// (0 when there is none or it is not in the supported list). Every item is
// handled by the character decode and the saturating multiply-by-ten
// accumulator between the parser state registers, so a new character can
// enter on every clock unless the input is stalled. Results pass through an
// output register backed by one skid entry; the input stalls only while that
// skid entry is occupied, so with the output side never stalling the rate is
// one item per cycle and a result shows in the cycle after its line end.
module gcode_line_parser_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_in_ch,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [gclp_pkg::CODE_W-1:0] o_out_code_kind
);
    import gclp_pkg::*;

    t_mode                 r_mode,         n_mode;
    logic [FIELD_W-1:0]    r_field,        n_field;
    logic                  r_negative,     n_negative;
    logic                  r_started,      n_started;
    logic                  r_point_seen,   n_point_seen;
    logic                  r_sign_taken,   n_sign_taken;
    logic [FRAC_W-1:0]     r_frac_count,   n_frac_count;
    logic [VALUE_BITS-1:0] r_accum,        n_accum;
    logic [CODE_W-1:0]     r_rec_code,     n_rec_code;

    logic                  buf_full;
    logic                  accept;
    logic                  res_valid;
    logic [CODE_W-1:0]     res_code;
    logic                  pass_on;
    logic                  is_digit;
    logic                  is_coord;
    logic                  is_end;
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] acc_next;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;
    assign is_digit   = (i_in_ch >= CH_ZERO) && (i_in_ch <= CH_NINE);
    assign digit      = i_in_ch[3:0];
    assign is_coord   = (r_field >= F_X) && (r_field <= F_F);
    assign is_end     = (i_in_ch == CH_CR) || (i_in_ch == CH_NUL);
    assign acc_next   = sat_mul10_add(r_accum, digit);

    always_comb begin
        n_mode       = r_mode;
        n_field      = r_field;
        n_negative   = r_negative;
        n_started    = r_started;
        n_point_seen = r_point_seen;
        n_sign_taken = r_sign_taken;
        n_frac_count = r_frac_count;
        n_accum      = r_accum;
        n_rec_code   = r_rec_code;
        res_valid    = 1'b0;
        res_code     = r_rec_code;
        pass_on      = 1'b1;

        if (accept) begin
            if (r_mode == ST_NUM) begin
                pass_on = 1'b0;
                if (is_digit) begin
                    if (!r_point_seen) begin
                        n_accum = acc_next;
                    end else if (r_frac_count < FRAC_W'(FRAC_DIGITS)) begin
                        n_accum      = acc_next;
                        n_frac_count = r_frac_count + 1'b1;
                    end
                    n_started    = 1'b1;
                    n_sign_taken = 1'b1;
                end else if (is_coord && (i_in_ch == CH_POINT) && !r_point_seen) begin
                    n_point_seen = 1'b1;
                    n_sign_taken = 1'b1;
                end else if (!r_sign_taken && is_blank(i_in_ch)) begin
                    // leading blank, dropped
                end else if (!r_sign_taken && ((i_in_ch == CH_PLUS) || (i_in_ch == CH_MINUS))) begin
                    n_sign_taken = 1'b1;
                    n_negative   = (i_in_ch == CH_MINUS);
                end else begin
                    // number ends here; the character is scanned as a token
                    if ((r_field == F_G) || (r_field == F_M)) begin
                        n_rec_code = map_code(r_field == F_G, r_negative, r_accum);
                    end
                    n_mode  = ST_TOKEN;
                    pass_on = 1'b1;
                end
            end

            if (pass_on) begin
                if (is_end) begin
                    res_valid  = 1'b1;
                    res_code   = n_rec_code;
                    n_rec_code = CK_UNKNOWN;
                    n_mode     = ST_TOKEN;
                end else if (r_mode == ST_COMMENT) begin
                    // rest of the line is comment
                end else if (i_in_ch == CH_SEMI) begin
                    n_mode = ST_COMMENT;
                end else begin
                    for (int i = 0; i < NUM_FIELDS; i++) begin
                        if (i_in_ch == WORD_LETTERS[i]) begin
                            n_mode       = ST_NUM;
                            n_field      = FIELD_W'(i);
                            n_negative   = 1'b0;
                            n_started    = 1'b0;
                            n_point_seen = 1'b0;
                            n_sign_taken = 1'b0;
                            n_frac_count = '0;
                            n_accum      = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ST_TOKEN;
            r_field      <= F_N;
            r_negative   <= 1'b0;
            r_started    <= 1'b0;
            r_point_seen <= 1'b0;
            r_sign_taken <= 1'b0;
            r_frac_count <= '0;
            r_accum      <= '0;
            r_rec_code   <= CK_UNKNOWN;
        end else begin
            r_mode       <= n_mode;
            r_field      <= n_field;
            r_negative   <= n_negative;
            r_started    <= n_started;
            r_point_seen <= n_point_seen;
            r_sign_taken <= n_sign_taken;
            r_frac_count <= n_frac_count;
            r_accum      <= n_accum;
            r_rec_code   <= n_rec_code;
        end
    end

    gclp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_code  (res_code),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_code  (o_out_code_kind)
    );

endmodule

FILE: rtl/gclp_out_buf.sv
// gclp_out_buf: output register with one skid entry for the parser results
// depends on gclp_pkg
`timescale 1ns / 1ps

module gclp_out_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_res_valid,
    input  logic [gclp_pkg::CODE_W-1:0] i_res_code,
    output logic                        o_full,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [gclp_pkg::CODE_W-1:0] o_out_code
);
    import gclp_pkg::*;

    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic              r_skid_valid;
    logic [CODE_W-1:0] r_skid_code;
    logic              out_fire;

    assign out_fire    = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_code  = r_out_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no item enters while the skid entry is held
            if (out_fire) begin
                r_out_code   <= r_skid_code;
                r_skid_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
                r_out_code  <= i_res_code;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_code  <= i_res_code;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for gcode_line_parser_unit, character items in, code_kind out
// depends on gclp_pkg and the parser rtl; predicts each line's command code in the testbench
`timescale 1ns / 1ps

module tb_top;
    import gclp_pkg::*;

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [63:0] LIM64 = 64'(VAL_LIMIT);
    localparam logic [7:0] BLANKS [5] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic [7:0]        i_in_ch = 8'h00;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [CODE_W-1:0] o_out_code_kind;

    gcode_line_parser_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_ch         (i_in_ch),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_code_kind (o_out_code_kind)
    );

    always #6 i_clk = ~i_clk;

    // parser shadow state
    t_mode              pm_mode = ST_TOKEN;
    logic [FIELD_W-1:0] pm_field = '0;
    logic               pm_neg = 1'b0;
    logic               pm_point = 1'b0;
    logic               pm_sign = 1'b0;
    int                 pm_frac = 0;
    logic [63:0]        pm_accum = '0;
    logic [CODE_W-1:0]  line_code = CK_UNKNOWN;

    logic [CODE_W-1:0] code_q[$];
    logic [7:0]        line_buf[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    int  sent_count = 0;
    bit  gaps_on = 1'b0;
    bit  stall_on = 1'b0;
    bit  long_hold_req = 1'b0;

    function automatic logic [63:0] mul10_sat(input logic [63:0] m, input logic [63:0] d);
        if (m > (LIM64 - d) / 10) begin
            return LIM64;
        end
        return m * 10 + d;
    endfunction

    function automatic logic [CODE_W-1:0] code_lookup(input logic is_g, input logic neg,
                                                      input logic [63:0] mag);
        logic [CODE_W-1:0] k;
        k = CK_UNKNOWN;
        if (!(neg && mag != 0)) begin
            if (is_g) begin
                for (int i = 0; i < G_COUNT; i++) begin
                    if (mag == 64'(G_TAB[i])) k = CK_G_BASE + CODE_W'(i);
                end
            end else begin
                for (int i = 0; i < M_COUNT; i++) begin
                    if (mag == 64'(M_TAB[i])) k = CK_M_BASE + CODE_W'(i);
                end
            end
        end
        return k;
    endfunction

    task automatic predict_char(input logic [7:0] c);
        logic        taken;
        logic        coord;
        logic        blank;
        logic [63:0] mag;
        taken = 1'b0;
        blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_FF);
        if (pm_mode == ST_NUM) begin
            coord = (pm_field >= F_X) && (pm_field <= F_F);
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (!pm_point) begin
                    pm_accum = mul10_sat(pm_accum, 64'(c - CH_ZERO));
                end else if (pm_frac < FRAC_DIGITS) begin
                    pm_accum = mul10_sat(pm_accum, 64'(c - CH_ZERO));
                    pm_frac++;
                end
                pm_sign = 1'b1;
                taken = 1'b1;
            end else if (coord && c == CH_POINT && !pm_point) begin
                pm_point = 1'b1;
                pm_sign = 1'b1;
                taken = 1'b1;
            end else if (!pm_sign && blank) begin
                taken = 1'b1;
            end else if (!pm_sign && (c == CH_PLUS || c == CH_MINUS)) begin
                pm_sign = 1'b1;
                pm_neg = (c == CH_MINUS);
                taken = 1'b1;
            end else begin
                // number ends here; only g and m words affect the code
                if (pm_field == F_G || pm_field == F_M) begin
                    mag = pm_accum;
                    if (!pm_neg && mag > LIM64 - 1) mag = LIM64 - 1;
                    line_code = code_lookup(pm_field == F_G, pm_neg, mag);
                end
                pm_mode = ST_TOKEN;
            end
        end
        if (!taken) begin
            if (c == CH_CR || c == CH_NUL) begin
                code_q.push_back(line_code);
                line_code = CK_UNKNOWN;
                pm_mode = ST_TOKEN;
            end else if (pm_mode == ST_TOKEN) begin
                if (c == CH_SEMI) begin
                    pm_mode = ST_COMMENT;
                end else begin
                    for (int i = 0; i < NUM_FIELDS; i++) begin
                        if (c == WORD_LETTERS[i]) begin
                            pm_mode = ST_NUM;
                            pm_field = FIELD_W'(i);
                            pm_neg = 1'b0;
                            pm_point = 1'b0;
                            pm_sign = 1'b0;
                            pm_frac = 0;
                            pm_accum = '0;
                        end
                    end
                end
            end
        end
    endtask

    // result check first, then prediction of the item accepted on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (code_q.size() == 0) begin
                    $error("code_kind: unexpected result, actual %0d", o_out_code_kind);
                    fail_count++;
                end else begin
                    if (o_out_code_kind !== code_q[0]) begin
                        $error("code_kind: expected %0d, actual %0d", code_q[0], o_out_code_kind);
                        fail_count++;
                    end
                    void'(code_q.pop_front());
                end
            end
            if (i_in_valid && !o_in_stall) predict_char(i_in_ch);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_ch <= c;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
    endtask

    task automatic add_str(input string s);
        for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
    endtask

    task automatic send_buf();
        foreach (line_buf[k]) send_char(line_buf[k]);
        line_buf.delete();
    endtask

    task automatic send_line(input string body, input logic [7:0] term);
        add_str(body);
        line_buf.push_back(term);
        send_buf();
    endtask

    task automatic wait_results_idle();
        i_in_valid <= 1'b0;
        while (code_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_digits(input int n);
        repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_number(input bit coord);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) line_buf.push_back(BLANKS[$urandom_range(0, 4)]);
        end
        case ($urandom_range(0, 3))
            0: line_buf.push_back(CH_PLUS);
            1: line_buf.push_back(CH_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: ;
            1: add_digits($urandom_range(10, 12));
            default: add_digits($urandom_range(1, 4));
        endcase
        if (coord && $urandom_range(0, 1) == 0) begin
            line_buf.push_back(CH_POINT);
            add_digits($urandom_range(0, 5));
        end
    endtask

    task automatic add_command_word();
        bit is_g;
        is_g = $urandom_range(0, 1);
        line_buf.push_back(WORD_LETTERS[is_g ? F_G : F_M]);
        if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 7) == 0) line_buf.push_back(CH_ZERO);
            if (is_g) begin
                add_str($sformatf("%0d", G_TAB[$urandom_range(0, G_COUNT - 1)]));
            end else begin
                add_str($sformatf("%0d", M_TAB[$urandom_range(0, M_COUNT - 1)]));
            end
        end else begin
            add_number(1'b0);
        end
    endtask

    // mostly well-formed lines with random content, some raw byte noise
    task automatic build_line();
        int idx;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                line_buf.push_back(WORD_LETTERS[F_N]);
                add_number(1'b0);
            end
            if ($urandom_range(0, 9) != 0) add_command_word();
            repeat ($urandom_range(0, 4)) begin
                idx = $urandom_range(3, NUM_FIELDS - 1);
                if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_SPACE);
                line_buf.push_back(WORD_LETTERS[idx]);
                add_number(idx >= F_X && idx <= F_F);
            end
            if ($urandom_range(0, 5) == 0) add_command_word();
            if ($urandom_range(0, 4) == 0) begin
                line_buf.push_back(CH_SEMI);
                repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(32, 126)));
            end
        end
        line_buf.push_back(($urandom_range(0, 6) == 0) ? CH_NUL : CH_CR);
    endtask

    task automatic test_special_lines();
        gaps_on = 1'b1;
        stall_on = 1'b1;
        send_line("", CH_CR);
        send_line("G-0", CH_NUL);
        send_line("G", CH_CR);
        send_line("M 105", CH_CR);
        send_line("G99999999999", CH_CR);
        send_line("X.G+", CH_CR);
        send_line("G1.5", CH_CR);
        send_line("G1E5", CH_CR);
        send_line(";", CH_CR);
        send_line("G28;c", CH_NUL);
        send_line("G1M501", CH_CR);
        send_line("G-1g1", CH_CR);
        send_line("M710", CH_CR);
        send_char(8'hFF);
        send_char(CH_CR);
        wait_results_idle();
    endtask

    task automatic test_random_lines(input int n_items);
        int goal;
        goal = sent_count + n_items;
        while (sent_count < goal) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            build_line();
            send_buf();
        end
        wait_results_idle();
    endtask

    // receiver holds off for a long stretch while line ends keep coming
    task automatic test_output_holdoff();
        gaps_on = 1'b0;
        stall_on = 1'b0;
        long_hold_req = 1'b1;
        repeat (20) begin
            line_buf.push_back(WORD_LETTERS[F_G]);
            add_str($sformatf("%0d", G_TAB[$urandom_range(0, G_COUNT - 1)]));
            line_buf.push_back(CH_CR);
            send_buf();
        end
        wait_results_idle();
    endtask

    task automatic test_full_rate();
        gaps_on = 1'b0;
        stall_on = 1'b0;
        while (sent_count < 1150) begin
            build_line();
            send_buf();
        end
        wait_results_idle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_lines();
        test_random_lines(800);
        test_output_holdoff();
        test_full_rate();
        repeat (8) @(posedge i_clk);
        if (code_q.size() != 0) begin
            $error("code_kind: %0d expected results never came", code_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: gcode_line_parser_unit.f
rtl/gclp_pkg.sv
rtl/gclp_out_buf.sv
rtl/gcode_line_parser_unit.sv
tb/tb_top.sv
